>>> sv/aapr_pkg.sv
// Shared types, constants and the arctangent table of the axis-angle point rotator.
package aapr_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS       = 16;
    localparam int AXIS_W          = 16;
    localparam int ANGLE_W         = 19;
    localparam int MAT_W           = 36;
    localparam int ANGLE_SHIFT     = 30 - FRAC_BITS;

    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [34:0] Q30_ONE     = 35'sd1073741824;
    localparam int                 CORDIC_STEPS = 30;

    typedef enum logic [1:0] {
        REG_AXIS_X = 2'd0,
        REG_AXIS_Y = 2'd1,
        REG_AXIS_Z = 2'd2,
        REG_ANGLE  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0]  axis_x;
        logic signed [AXIS_W-1:0]  axis_y;
        logic signed [AXIS_W-1:0]  axis_z;
        logic signed [ANGLE_W-1:0] angle;
    } aapr_cfg_t;

    typedef logic signed [MAT_W-1:0] mat_elem_t;

    // Arctangent of 2^-i in Q30.
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            5'd24:   v = 32'h0000003F;
            5'd25:   v = 32'h0000001F;
            5'd26:   v = 32'h0000000F;
            5'd27:   v = 32'h00000008;
            5'd28:   v = 32'h00000004;
            5'd29:   v = 32'h00000002;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

>>> sv/aapr_matrix.sv
// Sequential engine that derives the Rodrigues rotation matrix from the axis and angle.
module aapr_matrix
    import aapr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  aapr_cfg_t  cfg,
    output logic       busy,
    output mat_elem_t  mat [9]
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PREP  = 9'b000000010,
        S_CORD  = 9'b000000100,
        S_SCALE = 9'b000001000,
        S_SQRT  = 9'b000010000,
        S_DLD   = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_MUL   = 9'b010000000,
        S_ASM   = 9'b100000000
    } eng_state_t;

    eng_state_t         state_reg;
    logic signed [35:0] r_reg;
    logic signed [33:0] x_reg, y_reg;
    logic               flip_reg;
    logic [4:0]         it_reg;
    logic [31:0]        n2_reg;
    logic [4:0]         k_reg;
    logic [63:0]        sv_reg;
    logic [63:0]        res_reg;
    logic [4:0]         j_reg;
    logic [3:0]         d_reg;
    logic [63:0]        num_reg;
    logic [33:0]        den2_reg;
    logic [33:0]        rem_reg;
    logic [32:0]        quo_reg;
    logic               neg_reg;
    logic [5:0]         cnt_reg;
    logic signed [33:0] coef_reg [9];
    logic               ph_reg;
    logic [63:0]        pr_reg;
    logic               psg_reg;
    logic signed [34:0] prod_reg [9];
    mat_elem_t          mat_reg [9];

    function automatic logic [1:0] pair_i(input logic [3:0] d);
        logic [1:0] v;
        case (d)
            4'd3, 4'd4: v = 2'd1;
            4'd5:       v = 2'd2;
            default:    v = 2'd0;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] pair_j(input logic [3:0] d);
        logic [1:0] v;
        case (d)
            4'd1, 4'd3: v = 2'd1;
            4'd2, 4'd4, 4'd5: v = 2'd2;
            default:    v = 2'd0;
        endcase
        return v;
    endfunction

    // Angle reduction into [-pi/2, pi/2] with a sign flip of the result.
    logic signed [35:0] ang_s, r1_s, rf_s;
    logic               flip_s;
    always_comb
    begin
        ang_s = 36'(cfg.angle) <<< ANGLE_SHIFT;
        if (ang_s > PI_Q30)
            r1_s = ang_s - TWO_PI_Q30;
        else if (ang_s < -PI_Q30)
            r1_s = ang_s + TWO_PI_Q30;
        else
            r1_s = ang_s;
        flip_s = 1'b1;
        if (r1_s > HALF_PI_Q30)
            rf_s = r1_s - PI_Q30;
        else if (r1_s < -HALF_PI_Q30)
            rf_s = r1_s + PI_Q30;
        else
        begin
            rf_s   = r1_s;
            flip_s = 1'b0;
        end
    end

    logic signed [AXIS_W-1:0] a_w [3];
    assign a_w[0] = cfg.axis_x;
    assign a_w[1] = cfg.axis_y;
    assign a_w[2] = cfg.axis_z;

    logic [31:0] n2_s;
    always_comb
    begin
        n2_s = 32'($unsigned(32'(a_w[0] * a_w[0]))) + 32'($unsigned(32'(a_w[1] * a_w[1])))
             + 32'($unsigned(32'(a_w[2] * a_w[2])));
    end

    // CORDIC rotation step.
    logic signed [33:0] dx_s, dy_s, x_next, y_next;
    logic signed [35:0] at_s, r_next;
    always_comb
    begin
        dx_s = y_reg >>> it_reg;
        dy_s = x_reg >>> it_reg;
        at_s = $signed({4'b0, atan_q30(it_reg)});
        if (!r_reg[35])
        begin
            x_next = x_reg - dx_s;
            y_next = y_reg + dy_s;
            r_next = r_reg - at_s;
        end
        else
        begin
            x_next = x_reg + dx_s;
            y_next = y_reg - dy_s;
            r_next = r_reg + at_s;
        end
    end

    logic signed [33:0] c_w, s_w;
    logic signed [34:0] t_w;
    assign c_w = flip_reg ? -x_reg : x_reg;
    assign s_w = flip_reg ? -y_reg : y_reg;
    assign t_w = Q30_ONE - 35'(c_w);

    // Square root step.
    logic [63:0] bit_s, trial_s;
    assign bit_s   = 64'd1 << {j_reg, 1'b0};
    assign trial_s = res_reg + bit_s;

    // Division operand set-up.
    logic [1:0]         ii_s, jj_s;
    logic signed [15:0] ai_s, aj_s;
    logic signed [31:0] aprod_s;
    logic [31:0]        pmag_s;
    logic signed [16:0] ai17_s;
    logic [16:0]        amag_s;
    logic [63:0]        dmag_s, dden_s, dnum_s;
    logic               dneg_s;
    always_comb
    begin
        if (d_reg < 4'd6)
        begin
            ii_s = pair_i(d_reg);
            jj_s = pair_j(d_reg);
        end
        else
        begin
            ii_s = 2'(d_reg - 4'd6);
            jj_s = ii_s;
        end
        ai_s    = a_w[ii_s];
        aj_s    = a_w[jj_s];
        aprod_s = ai_s * aj_s;
        pmag_s  = aprod_s[31] ? 32'(-aprod_s) : 32'(aprod_s);
        ai17_s  = 17'(ai_s);
        amag_s  = ai17_s[16] ? 17'(-ai17_s) : 17'(ai17_s);
        if (d_reg < 4'd6)
        begin
            dmag_s = 64'(pmag_s) << 30;
            dden_s = 64'(n2_reg);
            dneg_s = ai_s[15] ^ aj_s[15];
        end
        else
        begin
            dmag_s = 64'(amag_s) << (6'd30 + 6'(k_reg));
            dden_s = 64'(res_reg[31:0]);
            dneg_s = ai_s[15];
        end
        dnum_s = (dmag_s << 1) + dden_s;
    end

    // Restoring division step.
    logic [34:0] remx_s;
    logic        qbit_s;
    logic [33:0] rem_next;
    logic [32:0] qfin_s;
    always_comb
    begin
        remx_s = {rem_reg, num_reg[63]};
        qbit_s = remx_s >= {1'b0, den2_reg};
        rem_next = qbit_s ? 34'(remx_s - {1'b0, den2_reg}) : remx_s[33:0];
        qfin_s = {quo_reg[31:0], qbit_s};
    end

    // Shared multiplier for the matrix terms.
    logic signed [33:0] ma_s;
    logic signed [34:0] mb_s;
    logic [31:0]        mam_s, mbm_s;
    logic [33:0]        rm_s;
    logic signed [34:0] rm35_s;
    always_comb
    begin
        ma_s   = coef_reg[d_reg];
        mb_s   = (d_reg < 4'd6) ? t_w : 35'(s_w);
        mam_s  = ma_s[33] ? 32'(-ma_s) : 32'(ma_s);
        mbm_s  = mb_s[34] ? 32'(-mb_s) : 32'(mb_s);
        rm_s   = 34'((pr_reg + 64'd536870912) >> 30);
        rm35_s = $signed({1'b0, rm_s});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else if (start)
        begin
            state_reg <= S_PREP;
        end
        else
        begin
            case (state_reg)
                S_IDLE:  state_reg <= S_IDLE;
                S_PREP:  state_reg <= S_CORD;
                S_CORD:
                begin
                    if (it_reg == 5'(CORDIC_STEPS - 1))
                        state_reg <= (n2_reg == 32'd0) ? S_MUL : S_SCALE;
                end
                S_SCALE:
                begin
                    if (!(k_reg < 5'd30 && sv_reg[63:60] == 4'd0))
                        state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (j_reg == 5'd0)
                        state_reg <= S_DLD;
                end
                S_DLD:   state_reg <= S_DIV;
                S_DIV:
                begin
                    if (cnt_reg == 6'd63)
                        state_reg <= (d_reg == 4'd8) ? S_MUL : S_DLD;
                end
                S_MUL:
                begin
                    if (ph_reg && d_reg == 4'd8)
                        state_reg <= S_ASM;
                end
                S_ASM:   state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            it_reg <= 5'd0;
        end
        else
        begin
            case (state_reg)
                S_PREP:
                begin
                    r_reg    <= rf_s;
                    flip_reg <= flip_s;
                    x_reg    <= CORDIC_GAIN;
                    y_reg    <= '0;
                    n2_reg   <= n2_s;
                    it_reg   <= 5'd0;
                    k_reg    <= 5'd0;
                    sv_reg   <= 64'(n2_s);
                    d_reg    <= 4'd0;
                    ph_reg   <= 1'b0;
                    for (int i = 0; i < 9; i++)
                        coef_reg[i] <= '0;
                end
                S_CORD:
                begin
                    x_reg  <= x_next;
                    y_reg  <= y_next;
                    r_reg  <= r_next;
                    it_reg <= it_reg + 5'd1;
                end
                S_SCALE:
                begin
                    if (k_reg < 5'd30 && sv_reg[63:60] == 4'd0)
                    begin
                        sv_reg <= sv_reg << 2;
                        k_reg  <= k_reg + 5'd1;
                    end
                    else
                    begin
                        res_reg <= '0;
                        j_reg   <= 5'd31;
                    end
                end
                S_SQRT:
                begin
                    if (sv_reg >= trial_s)
                    begin
                        sv_reg  <= sv_reg - trial_s;
                        res_reg <= (res_reg >> 1) + bit_s;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    j_reg <= j_reg - 5'd1;
                end
                S_DLD:
                begin
                    num_reg  <= dnum_s;
                    den2_reg <= 34'(dden_s << 1);
                    neg_reg  <= dneg_s;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    cnt_reg  <= 6'd0;
                end
                S_DIV:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= qfin_s;
                    num_reg <= num_reg << 1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        coef_reg[d_reg] <= neg_reg ? -$signed({1'b0, qfin_s})
                                                   : $signed({1'b0, qfin_s});
                        d_reg <= (d_reg == 4'd8) ? 4'd0 : d_reg + 4'd1;
                        ph_reg <= 1'b0;
                    end
                end
                S_MUL:
                begin
                    if (!ph_reg)
                    begin
                        pr_reg  <= 64'(mam_s) * 64'(mbm_s);
                        psg_reg <= ma_s[33] ^ mb_s[34];
                        ph_reg  <= 1'b1;
                    end
                    else
                    begin
                        prod_reg[d_reg] <= psg_reg ? -rm35_s : rm35_s;
                        ph_reg <= 1'b0;
                        if (d_reg != 4'd8)
                            d_reg <= d_reg + 4'd1;
                    end
                end
                S_ASM:
                begin
                    mat_reg[0] <= MAT_W'(c_w) + MAT_W'(prod_reg[0]);
                    mat_reg[1] <= MAT_W'(prod_reg[1]) - MAT_W'(prod_reg[8]);
                    mat_reg[2] <= MAT_W'(prod_reg[2]) + MAT_W'(prod_reg[7]);
                    mat_reg[3] <= MAT_W'(prod_reg[1]) + MAT_W'(prod_reg[8]);
                    mat_reg[4] <= MAT_W'(c_w) + MAT_W'(prod_reg[3]);
                    mat_reg[5] <= MAT_W'(prod_reg[4]) - MAT_W'(prod_reg[6]);
                    mat_reg[6] <= MAT_W'(prod_reg[2]) - MAT_W'(prod_reg[7]);
                    mat_reg[7] <= MAT_W'(prod_reg[4]) + MAT_W'(prod_reg[6]);
                    mat_reg[8] <= MAT_W'(c_w) + MAT_W'(prod_reg[5]);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign mat  = mat_reg;

endmodule

>>> sv/axis_angle_point_rotator_3d.sv
// Top level of the axis-angle point rotator: register port, matrix engine and point pipeline.
// An accepted item passes the partial-product, full-product, row-sum and result registers
// before it is valid. Throughput: one item per cycle while the matrix is ready and results
// are taken; stages advance independently, so bubbles are squeezed out. After reset and every
// register write, the engine rebuilds the matrix (CORDIC, scaling, square root, nine 64-step
// divisions, nine products), holding point_ready low. Reset is asynchronous and active low.
module axis_angle_point_rotator_3d
    import aapr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          point_valid,
    output logic                          point_ready,
    input  logic signed [COORD_WIDTH-1:0] x,
    input  logic signed [COORD_WIDTH-1:0] y,
    input  logic signed [COORD_WIDTH-1:0] z,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic signed [COORD_WIDTH-1:0] rotated_x,
    output logic signed [COORD_WIDTH-1:0] rotated_y,
    output logic signed [COORD_WIDTH-1:0] rotated_z
);

    // Coordinates are split into a signed upper half and an unsigned lower half so that
    // no single multiplier becomes wider than the matrix width by half a coordinate.
    localparam int LO_W     = COORD_WIDTH / 2;
    localparam int HI_W     = COORD_WIDTH - LO_W;
    localparam int PP_LO_W  = MAT_W + LO_W + 1;
    localparam int PP_HI_W  = MAT_W + HI_W;
    localparam int PW       = MAT_W + COORD_WIDTH;
    localparam int SW       = PW + 2;
    localparam logic signed [SW-1:0] ROUND_HALF = SW'(64'd536870912);
    localparam logic signed [SW-1:0] CMAX = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
    localparam logic signed [SW-1:0] CMIN = -(SW'(1) <<< (COORD_WIDTH - 1));

    // ------------------------------------------------------------------
    // Configuration registers. Addresses are decoded on the word index only.
    // ------------------------------------------------------------------
    logic signed [AXIS_W-1:0]  axis_x_reg, axis_y_reg, axis_z_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic                      boot_reg;
    logic                      cfg_wr;
    reg_idx_t                  widx;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign widx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_x_reg <= '0;
            axis_y_reg <= '0;
            axis_z_reg <= 16'sd16384;
            angle_reg  <= '0;
            boot_reg   <= 1'b1;
        end
        else
        begin
            boot_reg <= 1'b0;
            if (cfg_wr)
            begin
                case (widx)
                    REG_AXIS_X: axis_x_reg <= pwdata[AXIS_W-1:0];
                    REG_AXIS_Y: axis_y_reg <= pwdata[AXIS_W-1:0];
                    REG_AXIS_Z: axis_z_reg <= pwdata[AXIS_W-1:0];
                    REG_ANGLE:  angle_reg  <= pwdata[ANGLE_W-1:0];
                    default:    angle_reg  <= angle_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        case (widx)
            REG_AXIS_X: prdata = {16'h0, axis_x_reg};
            REG_AXIS_Y: prdata = {16'h0, axis_y_reg};
            REG_AXIS_Z: prdata = {16'h0, axis_z_reg};
            REG_ANGLE:  prdata = {13'h0, angle_reg};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Matrix engine. A rebuild starts on the first cycle after reset and on
    // every register write; the pipeline takes no item until it is done.
    // ------------------------------------------------------------------
    aapr_cfg_t  cfg;
    logic       start;
    logic       eng_busy;
    logic       mat_ok;
    mat_elem_t  mat [9];

    assign cfg.axis_x = axis_x_reg;
    assign cfg.axis_y = axis_y_reg;
    assign cfg.axis_z = axis_z_reg;
    assign cfg.angle  = angle_reg;
    assign start      = boot_reg | cfg_wr;
    assign mat_ok     = ~eng_busy & ~start;

    aapr_matrix u_matrix
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cfg   (cfg),
        .busy  (eng_busy),
        .mat   (mat)
    );

    // ------------------------------------------------------------------
    // Point pipeline. Stage one holds the item, stage two the partial
    // products, stage three the full products, stage four the rounded row
    // sums and stage five the saturated result. Each stage loads when it is
    // empty or when the stage after it loads, so a stall holds in place each item with no
    // empty stage ahead of it, and a waiting result does not stop earlier stages filling.
    // ------------------------------------------------------------------
    logic [4:0] vld_reg;
    logic [4:0] ld;

    always_comb
    begin
        ld[4] = ~vld_reg[4] | result_ready;
        for (int k = 3; k >= 0; k--)
            ld[k] = ~vld_reg[k] | ld[k+1];
    end

    assign point_ready = ld[0] & mat_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[0])
                vld_reg[0] <= point_valid & mat_ok;
            for (int k = 1; k < 5; k++)
            begin
                if (ld[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    logic signed [COORD_WIDTH-1:0] p_reg    [3];
    logic signed [PP_LO_W-1:0]     pplo_reg [9];
    logic signed [PP_HI_W-1:0]     pphi_reg [9];
    logic signed [PW-1:0]          full_reg [9];
    logic signed [SW-1:0]          sum_reg  [3];
    logic signed [COORD_WIDTH-1:0] out_reg  [3];

    logic signed [SW-1:0] sh_s  [3];
    logic signed [COORD_WIDTH-1:0] sat_s [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sh_s[r] = sum_reg[r] >>> 30;
            if (sh_s[r] > CMAX)
                sat_s[r] = CMAX[COORD_WIDTH-1:0];
            else if (sh_s[r] < CMIN)
                sat_s[r] = CMIN[COORD_WIDTH-1:0];
            else
                sat_s[r] = sh_s[r][COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            p_reg[0] <= x;
            p_reg[1] <= y;
            p_reg[2] <= z;
        end
        if (ld[1])
        begin
            for (int e = 0; e < 9; e++)
            begin
                pplo_reg[e] <= mat[e] * $signed({1'b0, p_reg[e % 3][LO_W-1:0]});
                pphi_reg[e] <= mat[e] * $signed(p_reg[e % 3][COORD_WIDTH-1:LO_W]);
            end
        end
        if (ld[2])
        begin
            for (int e = 0; e < 9; e++)
                full_reg[e] <= (PW'(pphi_reg[e]) <<< LO_W) + PW'(pplo_reg[e]);
        end
        if (ld[3])
        begin
            for (int r = 0; r < 3; r++)
                sum_reg[r] <= SW'(full_reg[3*r]) + SW'(full_reg[3*r+1])
                            + SW'(full_reg[3*r+2]) + ROUND_HALF;
        end
        if (ld[4])
        begin
            for (int r = 0; r < 3; r++)
                out_reg[r] <= sat_s[r];
        end
    end

    assign result_valid = vld_reg[4];
    assign rotated_x    = out_reg[0];
    assign rotated_y    = out_reg[1];
    assign rotated_z    = out_reg[2];

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    a_no_take_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> !point_ready)
        else $error("item taken while the matrix was being rebuilt");

    a_result_from_stage4: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(vld_reg[3]))
        else $error("result appeared without an item in the row-sum stage");

    a_matrix_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (mat_ok && $past(mat_ok)) |-> ($stable(mat[0]) && $stable(mat[4]) && $stable(mat[8])))
        else $error("matrix changed while items could be in flight");

endmodule
